>>> hdl/wav_header_parser_top_macros.svh
// Assertion macros shared by the WAV header parser modules.
`ifndef WAV_HEADER_PARSER_TOP_MACROS_SVH
`define WAV_HEADER_PARSER_TOP_MACROS_SVH

// A property checked at every clock edge outside reset.
`define WAV_HP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition that must hold at every clock edge outside reset.
`define WAV_HP_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

`endif

>>> hdl/wav_hp_pkg.sv
// Types, codes and constants shared by the WAV header parser modules.
package wav_hp_pkg;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CW = $clog2(DIV_STEPS);
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_STEPS - 1);
    localparam int FRAME_W = 29;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;
    localparam logic [31:0] BASE_FMT_SIZE = 32'd16;
    localparam logic [31:0] FMT_TAG_PCM = 32'd1;

    localparam logic [2:0] K_HEADER = 3'd0;
    localparam logic [2:0] K_DONE = 3'd1;
    localparam logic [2:0] K_SAMPLE = 3'd2;
    localparam logic [2:0] K_IGNORED = 3'd3;
    localparam logic [2:0] K_ERROR = 3'd4;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_NO_RIFF = 3'd1;
    localparam logic [2:0] ERR_NO_WAVE = 3'd2;
    localparam logic [2:0] ERR_NO_FMT = 3'd3;
    localparam logic [2:0] ERR_NOT_PCM = 3'd4;
    localparam logic [2:0] ERR_NO_DATA = 3'd5;
    localparam logic [2:0] ERR_ZERO_FRAME = 3'd6;

    typedef enum logic [15:0] {
        PH_RIFF      = 16'h0001,
        PH_RIFF_SIZE = 16'h0002,
        PH_WAVE      = 16'h0004,
        PH_FMT       = 16'h0008,
        PH_FMT_SIZE  = 16'h0010,
        PH_TAG       = 16'h0020,
        PH_CHANNELS  = 16'h0040,
        PH_RATE      = 16'h0080,
        PH_AVG       = 16'h0100,
        PH_ALIGN     = 16'h0200,
        PH_BITS      = 16'h0400,
        PH_SKIP      = 16'h0800,
        PH_DATA      = 16'h1000,
        PH_DATA_SIZE = 16'h2000,
        PH_SAMPLES   = 16'h4000,
        PH_END       = 16'h8000
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_DIV = 2'b10
    } t_seq;

    typedef struct packed {
        logic               start;
        logic [31:0]        dividend;
        logic [FRAME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [31:0]        quot;
        logic [FRAME_W-1:0] rem;
    } t_div_rsp;

    // Index of the last byte of the header field read in a phase.
    function automatic logic [1:0] f_field_last(input t_phase ph);
        logic [1:0] last;
        case (ph)
            PH_TAG, PH_CHANNELS, PH_ALIGN, PH_BITS: last = 2'd1;
            default: last = 2'd3;
        endcase
        return last;
    endfunction

endpackage

>>> hdl/wav_hp_div.sv
// Restoring divider that produces one quotient bit per cycle.
`include "wav_header_parser_top_macros.svh"

module wav_hp_div
    import wav_hp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CW-1:0]    r_cnt;
    logic [31:0]          r_quot;
    logic [FRAME_W-1:0]   r_rem;
    logic [FRAME_W-1:0]   r_dsor;
    logic [FRAME_W:0]     w_trial;
    logic [FRAME_W:0]     w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_quot[31]};
    assign w_ge    = w_trial >= {1'b0, r_dsor};
    assign w_diff  = w_trial - {1'b0, r_dsor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_dsor <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[30:0], w_ge};
            r_rem  <= w_ge ? w_diff[FRAME_W-1:0] : w_trial[FRAME_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

    `WAV_HP_ASSERT(a_busy_not_done, r_busy |-> !r_done, "divider busy and done at once")
    `WAV_HP_ASSERT(a_finish, r_busy && r_cnt == DIV_LAST |=> r_done, "divider missed its last step")
    `WAV_HP_CHECK(a_rem_range, !r_done || r_rem < r_dsor, "remainder not below divisor")

endmodule

>>> hdl/wav_header_parser_top.sv
// WAV header parser: each accepted byte beat gives one registered result beat
// in the next cycle. Takes one byte per cycle while o_stall is low; the last
// data size byte, if the frame size is nonzero, loads the serial divider,
// which runs 32 steps while the input stalls; its done flag then yields that
// byte's result beat. Synchronous active-low reset returns the parser to the
// RIFF identifier with reported header fields zero; there is no clearing pass.
`include "wav_header_parser_top_macros.svh"

module wav_header_parser_top
    import wav_hp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_file_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_sample_rate,
    output logic [15:0] o_sample_bits,
    output logic [31:0] o_frame_count,
    output logic        o_size_mismatch,
    output logic [7:0]  o_sample_byte,
    output logic        o_last_sample
);

    t_seq               r_seq, n_seq;
    t_phase             r_phase, n_phase;
    logic [1:0]         r_idx, n_idx;
    logic [31:0]        r_left, n_left;
    logic [31:0]        r_fmt, n_fmt;
    logic [15:0]        r_chan, n_chan;
    logic [31:0]        r_rate, n_rate;
    logic [15:0]        r_bits, n_bits;
    logic [31:0]        r_frames, n_frames;
    logic               r_mis, n_mis;
    logic [2:0]         r_err, n_err;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_kind, n_kind;
    logic [7:0]         r_sbyte, n_sbyte;
    logic               r_last, n_last;

    t_phase             w_phase;
    logic [1:0]         w_idx;
    logic [31:0]        w_left;
    logic [2:0]         w_err;
    logic [31:0]        w_acc;
    logic [31:0]        w_dec;
    logic [31:0]        w_bytes;
    logic               w_out_busy;
    logic               w_in_acc;
    t_div_req           w_req;
    t_div_rsp           w_rsp;

    wav_hp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_out_busy = r_out_valid && i_stall;
    assign o_stall    = (r_seq != ST_RUN) || w_out_busy;
    assign w_in_acc   = i_valid && !o_stall;

    assign w_phase = i_file_start ? PH_RIFF : r_phase;
    assign w_idx   = i_file_start ? 2'd0 : r_idx;
    assign w_left  = i_file_start ? 32'd0 : r_left;
    assign w_err   = i_file_start ? ERR_NONE : r_err;
    assign w_acc   = w_left | ({24'd0, i_in_byte} << {w_idx, 3'b000});
    assign w_dec   = (w_left != 32'd0) ? w_left - 32'd1 : 32'd0;
    assign w_bytes = r_left - {3'd0, w_rsp.rem};

    always_comb begin
        n_seq       = r_seq;
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_left      = r_left;
        n_fmt       = r_fmt;
        n_chan      = r_chan;
        n_rate      = r_rate;
        n_bits      = r_bits;
        n_frames    = r_frames;
        n_mis       = r_mis;
        n_err       = r_err;
        n_frame     = r_frame;
        n_out_valid = w_out_busy;
        n_kind      = r_kind;
        n_sbyte     = r_sbyte;
        n_last      = r_last;
        w_req       = '0;

        if (r_seq == ST_DIV) begin
            if (w_rsp.done && !w_out_busy) begin
                n_frames    = w_rsp.quot;
                n_mis       = w_rsp.rem != '0;
                n_left      = w_bytes;
                n_phase     = (w_bytes != 32'd0) ? PH_SAMPLES : PH_END;
                n_kind      = K_DONE;
                n_sbyte     = 8'd0;
                n_last      = 1'b0;
                n_out_valid = 1'b1;
                n_seq       = ST_RUN;
            end
        end else if (w_in_acc) begin
            if (i_file_start) begin
                n_fmt    = 32'd0;
                n_chan   = 16'd0;
                n_rate   = 32'd0;
                n_bits   = 16'd0;
                n_frames = 32'd0;
                n_mis    = 1'b0;
                n_err    = ERR_NONE;
                n_phase  = PH_RIFF;
                n_idx    = 2'd0;
                n_left   = 32'd0;
            end
            n_out_valid = 1'b1;
            n_kind      = K_HEADER;
            n_sbyte     = 8'd0;
            n_last      = 1'b0;
            case (w_phase)
                PH_END: begin
                    n_kind = (w_err != ERR_NONE) ? K_ERROR : K_IGNORED;
                end
                PH_SKIP: begin
                    n_left = w_dec;
                    if (w_dec == 32'd0) begin
                        n_phase = PH_DATA;
                    end
                end
                PH_SAMPLES: begin
                    n_kind  = K_SAMPLE;
                    n_sbyte = i_in_byte;
                    n_left  = w_dec;
                    if (w_dec == 32'd0) begin
                        n_last  = 1'b1;
                        n_phase = PH_END;
                    end
                end
                default: begin
                    n_left = w_acc;
                    n_idx  = w_idx + 2'd1;
                    if (w_idx == f_field_last(w_phase)) begin
                        n_idx  = 2'd0;
                        n_left = 32'd0;
                        case (w_phase)
                            PH_RIFF: begin
                                if (w_acc != ID_RIFF) begin
                                    n_err   = ERR_NO_RIFF;
                                    n_phase = PH_END;
                                    n_kind  = K_ERROR;
                                end else begin
                                    n_phase = PH_RIFF_SIZE;
                                end
                            end
                            PH_RIFF_SIZE: n_phase = PH_WAVE;
                            PH_WAVE: begin
                                if (w_acc != ID_WAVE) begin
                                    n_err   = ERR_NO_WAVE;
                                    n_phase = PH_END;
                                    n_kind  = K_ERROR;
                                end else begin
                                    n_phase = PH_FMT;
                                end
                            end
                            PH_FMT: begin
                                if (w_acc != ID_FMT) begin
                                    n_err   = ERR_NO_FMT;
                                    n_phase = PH_END;
                                    n_kind  = K_ERROR;
                                end else begin
                                    n_phase = PH_FMT_SIZE;
                                end
                            end
                            PH_FMT_SIZE: begin
                                n_fmt   = w_acc;
                                n_phase = PH_TAG;
                            end
                            PH_TAG: begin
                                if (w_acc != FMT_TAG_PCM) begin
                                    n_err   = ERR_NOT_PCM;
                                    n_phase = PH_END;
                                    n_kind  = K_ERROR;
                                end else begin
                                    n_phase = PH_CHANNELS;
                                end
                            end
                            PH_CHANNELS: begin
                                n_chan  = w_acc[15:0];
                                n_phase = PH_RATE;
                            end
                            PH_RATE: begin
                                n_rate  = w_acc;
                                n_phase = PH_AVG;
                            end
                            PH_AVG: n_phase = PH_ALIGN;
                            PH_ALIGN: n_phase = PH_BITS;
                            PH_BITS: begin
                                n_bits  = w_acc[15:0];
                                n_frame = FRAME_W'(r_chan) * FRAME_W'(w_acc[15:3]);
                                if (r_fmt > BASE_FMT_SIZE) begin
                                    n_left  = r_fmt - BASE_FMT_SIZE;
                                    n_phase = PH_SKIP;
                                end else begin
                                    n_phase = PH_DATA;
                                end
                            end
                            PH_DATA: begin
                                if (w_acc != ID_DATA) begin
                                    n_err   = ERR_NO_DATA;
                                    n_phase = PH_END;
                                    n_kind  = K_ERROR;
                                end else begin
                                    n_phase = PH_DATA_SIZE;
                                end
                            end
                            PH_DATA_SIZE: begin
                                if (r_frame == '0) begin
                                    n_err   = ERR_ZERO_FRAME;
                                    n_phase = PH_END;
                                    n_kind  = K_ERROR;
                                end else begin
                                    w_req.start    = 1'b1;
                                    w_req.dividend = w_acc;
                                    w_req.divisor  = r_frame;
                                    n_left         = w_acc;
                                    n_seq          = ST_DIV;
                                    n_out_valid    = w_out_busy;
                                    n_kind         = r_kind;
                                    n_sbyte        = r_sbyte;
                                    n_last         = r_last;
                                end
                            end
                            default: n_phase = PH_RIFF;
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= ST_RUN;
            r_phase     <= PH_RIFF;
            r_idx       <= 2'd0;
            r_left      <= 32'd0;
            r_fmt       <= 32'd0;
            r_chan      <= 16'd0;
            r_rate      <= 32'd0;
            r_bits      <= 16'd0;
            r_frames    <= 32'd0;
            r_mis       <= 1'b0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_left      <= n_left;
            r_fmt       <= n_fmt;
            r_chan      <= n_chan;
            r_rate      <= n_rate;
            r_bits      <= n_bits;
            r_frames    <= n_frames;
            r_mis       <= n_mis;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        r_kind  <= n_kind;
        r_sbyte <= n_sbyte;
        r_last  <= n_last;
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_kind;
    assign o_error_code    = r_err;
    assign o_channel_count = r_chan;
    assign o_sample_rate   = r_rate;
    assign o_sample_bits   = r_bits;
    assign o_frame_count   = r_frames;
    assign o_size_mismatch = r_mis;
    assign o_sample_byte   = r_sbyte;
    assign o_last_sample   = r_last;

    `WAV_HP_ASSERT(a_div_stalls, r_seq == ST_DIV |-> o_stall, "byte taken while dividing")
    `WAV_HP_ASSERT(a_last_kind, o_valid && o_last_sample |-> o_kind == K_SAMPLE, "last flag off a sample")
    `WAV_HP_ASSERT(a_err_ends, r_err != ERR_NONE |-> r_phase == PH_END, "error held outside end phase")

endmodule
